// ===== sv/vrp_pkg.sv =====
// vrp_pkg: shared types, codes and constants of the voxel ray pick block
// no dependencies; imported by every module of the block
package vrp_pkg;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_PICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // face codes of a result beat
  typedef enum logic [2:0] {
    FACE_NONE  = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_X = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Y = 3'd4,
    FACE_NEG_Z = 3'd5,
    FACE_POS_Z = 3'd6
  } face_t;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_DIST   = 2'd0;
  localparam logic [1:0] CFG_MARCH_STEP = 2'd1;
  localparam logic [1:0] CFG_FACE_TOL   = 2'd2;

  // configuration reset values
  localparam logic [14:0] MAX_DIST_RST   = 15'd3840;
  localparam logic [11:0] MARCH_STEP_RST = 12'd26;
  localparam logic [7:0]  FACE_TOL_RST   = 8'd1;

  // slab time width and the open bound used for a zero direction component
  localparam int TW = 42;
  localparam logic signed [TW-1:0] T_UNB = 42'sh100_0000_0000;

  // width of a bound minus origin difference, and of the divider
  localparam int DIFF_W    = 18;
  localparam int DIVIDEND_W = 31;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = 5;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_M_MUL,
    ST_M_RD,
    ST_M_CHK,
    ST_S_AXIS,
    ST_S_DLO,
    ST_S_DHI,
    ST_S_MERGE,
    ST_S_CHECK,
    ST_F_MUL,
    ST_F_CHK,
    ST_EMIT_HIT,
    ST_EMIT_MISS
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_step;
    logic wr_cell;
    logic load;
    logic mul_march;
    logic rd_march;
    logic adv_march;
    logic axis_clr;
    logic axis_inc;
    logic axis_zero;
    logic div_start;
    logic div_hi;
    logic take_lo;
    logic take_hi;
    logic merge;
    logic face_mul;
    logic set_face;
    logic emit;
    logic emit_hit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic march_end;
    logic sample_hit;
    logic axis_last;
    logic dir_zero;
    logic div_done;
    logic slab_fail;
    logic face_hit;
  } stat_t;

  // face code of an axis and side
  function automatic face_t face_code(input logic [1:0] axis, input logic pos);
    face_t f;
    case (axis)
      2'd0:    f = pos ? FACE_POS_X : FACE_NEG_X;
      2'd1:    f = pos ? FACE_POS_Y : FACE_NEG_Y;
      2'd2:    f = pos ? FACE_POS_Z : FACE_NEG_Z;
      default: f = FACE_NONE;
    endcase
    return f;
  endfunction

endpackage

// ===== sv/vrp_divider.sv =====
// vrp_divider: signed slab time divider, one quotient bit per cycle
// depends on vrp_pkg
module vrp_divider import vrp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DIVIDEND_W-1:0]       dividend,
  input  logic [DIVISOR_W-1:0]        divisor,
  input  logic                        negate,
  output logic                        done,
  output logic signed [DIVIDEND_W:0]  quotient
);

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  den_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r, done_r, neg_r;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;

  // restoring step
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVIDEND_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? DIVISOR_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIVISOR_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
      neg_r <= negate;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

// ===== sv/vrp_datapath.sv =====
// vrp_datapath: occupancy memory, march sampler, slab test and face check
// depends on vrp_pkg and vrp_divider
module vrp_datapath import vrp_pkg::*; #(
  parameter int GRID_SIZE = 32,
  parameter int MAX_STEPS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [1:0]         in_operation,
  input  logic [4:0]         in_cell_x,
  input  logic [4:0]         in_cell_y,
  input  logic [4:0]         in_cell_z,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic signed [15:0] in_origin_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  output logic               out_valid,
  output logic               out_hit,
  output logic [2:0]         out_face,
  output logic signed [6:0]  out_place_x,
  output logic signed [6:0]  out_place_y,
  output logic signed [6:0]  out_place_z
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = $clog2(MAX_STEPS + 1);

  // configuration registers
  logic [14:0] max_dist_r;
  logic [11:0] step_r;
  logic [7:0]  tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= MAX_DIST_RST;
      step_r     <= MARCH_STEP_RST;
      tol_r      <= FACE_TOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_DIST:   max_dist_r <= cfg_data;
        CFG_MARCH_STEP: step_r     <= cfg_data[11:0];
        CFG_FACE_TOL:   tol_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // occupancy memory with clearing pass after reset
  logic           mem [DEPTH];
  logic [AW-1:0]  clr_addr_r;
  logic [AW-1:0]  wr_addr, rd_addr, set_addr;
  logic           wr_en, wr_data, set_in_grid;
  logic           mem_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
  end

  always_comb begin
    set_in_grid = (int'(in_cell_x) < GRID_SIZE) && (int'(in_cell_y) < GRID_SIZE) &&
                  (int'(in_cell_z) < GRID_SIZE);
    set_addr    = {CW'(in_cell_x), CW'(in_cell_y), CW'(in_cell_z)};
    wr_en       = cmd.clr_step | (cmd.wr_cell & set_in_grid);
    wr_addr     = cmd.clr_step ? clr_addr_r : set_addr;
    wr_data     = !cmd.clr_step && (in_operation == OP_SET);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_q_r <= mem[rd_addr];
  end

  // ray operands
  logic signed [15:0] org_r [3];
  logic signed [15:0] dir_r [3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      org_r[0] <= in_origin_x;
      org_r[1] <= in_origin_y;
      org_r[2] <= in_origin_z;
      dir_r[0] <= in_dir_x;
      dir_r[1] <= in_dir_y;
      dir_r[2] <= in_dir_z;
    end
  end

  // march distance and sample count
  logic [15:0]   dist_r;
  logic [SW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dist_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.adv_march) begin
      dist_r <= dist_r + {4'b0, step_r};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // sample products, registered
  logic signed [31:0] mprod_r [3];

  always_ff @(posedge clk) begin
    if (cmd.mul_march) begin
      for (int k = 0; k < 3; k++) begin
        mprod_r[k] <= $signed({1'b0, dist_r[14:0]}) * dir_r[k];
      end
    end
  end

  // sample cell and grid bounds
  logic signed [32:0] msum [3];
  logic signed [19:0] samp [3];
  logic signed [11:0] smp_cell [3];
  logic               in_grid;

  always_comb begin
    in_grid = 1'b1;
    for (int k = 0; k < 3; k++) begin
      msum[k]     = 33'(mprod_r[k]) + 33'sd8192;
      samp[k]     = 20'(org_r[k]) + 20'(msum[k] >>> 14);
      smp_cell[k] = 12'((samp[k] + 20'sd128) >>> 8);
      in_grid     = in_grid && (smp_cell[k] >= 0) && (smp_cell[k] < GRID_SIZE);
    end
    rd_addr = {CW'(smp_cell[0]), CW'(smp_cell[1]), CW'(smp_cell[2])};
  end

  logic [CW-1:0] cell_r [3];
  logic          inb_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_march) begin
      for (int k = 0; k < 3; k++) cell_r[k] <= CW'(smp_cell[k]);
      inb_r <= in_grid;
    end
  end

  // axis selector shared by slab and face steps
  logic [1:0] axis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) axis_r <= '0;
    else if (cmd.axis_clr) axis_r <= '0;
    else if (cmd.axis_inc) axis_r <= axis_r + 1'b1;
  end

  logic signed [15:0]       ocur, dcur;
  logic [CW-1:0]            ccur;
  logic signed [DIFF_W-1:0] lo_cur, hi_cur, num;
  logic [DIFF_W-2:0]        num_mag;
  logic [DIVISOR_W-1:0]     dmag;
  logic                     org_in;

  // bounds of the hit cube on the current axis and divider operands
  always_comb begin
    ocur    = org_r[axis_r];
    dcur    = dir_r[axis_r];
    ccur    = cell_r[axis_r];
    lo_cur  = $signed(DIFF_W'({ccur, 8'h00})) - 18'sd128;
    hi_cur  = lo_cur + 18'sd256;
    org_in  = (ocur >= lo_cur) && (ocur <= hi_cur);
    num     = (cmd.div_hi ? hi_cur : lo_cur) - DIFF_W'(ocur);
    num_mag = num[DIFF_W-1] ? (DIFF_W-1)'(-num) : num[DIFF_W-2:0];
    dmag    = dcur[15] ? DIVISOR_W'(-dcur) : DIVISOR_W'(dcur);
  end

  logic signed [DIVIDEND_W:0] div_q;
  logic                       div_done;

  vrp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({num_mag, 14'b0}),
    .divisor  (dmag),
    .negate   (num[DIFF_W-1] ^ dcur[15]),
    .done     (div_done),
    .quotient (div_q)
  );

  // per-axis slab interval
  logic signed [TW-1:0] qa_r, qb_r, t0, t1;
  logic                 pass_r;

  always_ff @(posedge clk) begin
    if (cmd.axis_zero) begin
      qa_r   <= -T_UNB;
      qb_r   <= T_UNB;
      pass_r <= org_in;
    end else begin
      if (cmd.div_start) pass_r <= 1'b1;
      if (cmd.take_lo) qa_r <= TW'(div_q);
      if (cmd.take_hi) qb_r <= TW'(div_q);
    end
  end

  assign t0 = (qa_r < qb_r) ? qa_r : qb_r;
  assign t1 = (qa_r < qb_r) ? qb_r : qa_r;

  // interval merge across axes
  logic signed [TW-1:0] tmin_r, tmax_r;
  logic                 fail_r;

  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      if (axis_r == 2'd0) begin
        tmin_r <= t0;
        tmax_r <= t1;
        fail_r <= !pass_r;
      end else begin
        fail_r <= fail_r || !pass_r || (tmin_r > t1) || (t0 > tmax_r);
        tmin_r <= (t0 > tmin_r) ? t0 : tmin_r;
        tmax_r <= (t1 < tmax_r) ? t1 : tmax_r;
      end
    end
  end

  // hit point product, registered
  logic signed [46:0] fprod_r;

  always_ff @(posedge clk) begin
    if (cmd.face_mul) fprod_r <= $signed({1'b0, tmin_r[30:0]}) * dcur;
  end

  // hit point against the two face planes of the current axis
  logic signed [47:0] fsum;
  logic signed [34:0] hpt, dlo, dhi;
  logic signed [8:0]  tol_s;
  logic               near_lo, near_hi;
  face_t              face_sel;

  always_comb begin
    fsum     = 48'(fprod_r) + 48'sd8192;
    hpt      = 35'(ocur) + 35'(fsum >>> 14);
    dlo      = hpt - 35'(lo_cur);
    dhi      = hpt - 35'(hi_cur);
    tol_s    = $signed({1'b0, tol_r});
    near_lo  = (dlo < tol_s) && (dlo > -tol_s);
    near_hi  = (dhi < tol_s) && (dhi > -tol_s);
    face_sel = face_code(axis_r, !near_lo);
  end

  face_t face_r;

  always_ff @(posedge clk) begin
    if (cmd.load) face_r <= FACE_NONE;
    else if (cmd.set_face) face_r <= face_sel;
  end

  // placement offset from the face
  logic signed [6:0] off [3];

  always_comb begin
    for (int k = 0; k < 3; k++) off[k] = '0;
    case (face_r)
      FACE_NEG_X: off[0] = -7'sd1;
      FACE_POS_X: off[0] = 7'sd1;
      FACE_NEG_Y: off[1] = -7'sd1;
      FACE_POS_Y: off[1] = 7'sd1;
      FACE_NEG_Z: off[2] = -7'sd1;
      FACE_POS_Z: off[2] = 7'sd1;
      default: ;
    endcase
  end

  // result beat and kept placement
  logic              out_valid_r, out_hit_r;
  face_t             out_face_r;
  logic signed [6:0] last_x_r, last_y_r, last_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.emit && cmd.emit_hit) begin
        last_x_r <= $signed(7'(cell_r[0])) + off[0];
        last_y_r <= $signed(7'(cell_r[1])) + off[1];
        last_z_r <= $signed(7'(cell_r[2])) + off[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit_r  <= cmd.emit_hit;
      out_face_r <= face_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_face    = out_face_r;
  assign out_place_x = last_x_r;
  assign out_place_y = last_y_r;
  assign out_place_z = last_z_r;

  // status
  always_comb begin
    stat.clr_done   = (clr_addr_r == {AW{1'b1}});
    stat.march_end  = (cnt_r == SW'(MAX_STEPS)) || (dist_r >= {1'b0, max_dist_r});
    stat.sample_hit = inb_r & mem_q_r;
    stat.axis_last  = (axis_r == 2'd2);
    stat.dir_zero   = (dcur == '0);
    stat.div_done   = div_done;
    stat.slab_fail  = fail_r || (tmin_r < 0);
    stat.face_hit   = near_lo | near_hi;
  end

endmodule

// ===== sv/vrp_ctrl.sv =====
// vrp_ctrl: sequencer for set, clear and pick beats
// depends on vrp_pkg
module vrp_ctrl import vrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_operation,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (in_operation)
            OP_SET, OP_CLEAR: cmd.wr_cell = 1'b1;
            OP_PICK: begin
              cmd.load  = 1'b1;
              state_nxt = ST_M_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_M_MUL: begin
        if (stat.march_end) begin
          state_nxt = ST_EMIT_MISS;
        end else begin
          cmd.mul_march = 1'b1;
          state_nxt     = ST_M_RD;
        end
      end
      ST_M_RD: begin
        cmd.rd_march = 1'b1;
        state_nxt    = ST_M_CHK;
      end
      ST_M_CHK: begin
        if (stat.sample_hit) begin
          cmd.axis_clr = 1'b1;
          state_nxt    = ST_S_AXIS;
        end else begin
          cmd.adv_march = 1'b1;
          state_nxt     = ST_M_MUL;
        end
      end
      ST_S_AXIS: begin
        if (stat.dir_zero) begin
          cmd.axis_zero = 1'b1;
          state_nxt     = ST_S_MERGE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_S_DLO;
        end
      end
      ST_S_DLO: begin
        if (stat.div_done) begin
          cmd.take_lo   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_hi    = 1'b1;
          state_nxt     = ST_S_DHI;
        end
      end
      ST_S_DHI: begin
        if (stat.div_done) begin
          cmd.take_hi = 1'b1;
          state_nxt   = ST_S_MERGE;
        end
      end
      ST_S_MERGE: begin
        cmd.merge = 1'b1;
        if (stat.axis_last) begin
          cmd.axis_clr = 1'b1;
          state_nxt    = ST_S_CHECK;
        end else begin
          cmd.axis_inc = 1'b1;
          state_nxt    = ST_S_AXIS;
        end
      end
      ST_S_CHECK: begin
        state_nxt = stat.slab_fail ? ST_EMIT_HIT : ST_F_MUL;
      end
      ST_F_MUL: begin
        cmd.face_mul = 1'b1;
        state_nxt    = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (stat.face_hit) begin
          cmd.set_face = 1'b1;
          state_nxt    = ST_EMIT_HIT;
        end else if (stat.axis_last) begin
          state_nxt = ST_EMIT_HIT;
        end else begin
          cmd.axis_inc = 1'b1;
          state_nxt    = ST_F_MUL;
        end
      end
      ST_EMIT_HIT: begin
        cmd.emit     = 1'b1;
        cmd.emit_hit = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_EMIT_MISS: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== sv/voxel_ray_pick.sv =====
// voxel_ray_pick: top level of the voxel ray pick block
// depends on vrp_pkg, vrp_ctrl and vrp_datapath
//
//   channel   ports                               flow
//   input     start, busy, in_*                   start while busy low takes a beat
//   result    out_valid, out_*                    one cycle strobe, no back pressure
//   config    cfg_we, cfg_index, cfg_data         write on any edge with cfg_we
//
// a set or clear beat is written from the idle state; a pick runs march samples
// (multiply, grid read, check), then on a hit up to six slab divisions through
// one serial divider and, if the slab test passes, a face check per axis
// (multiply, check), then an emit
// after reset a clearing pass writes all 32768 words (by default) of the occupancy
// memory with busy high; config writes are still taken
// the result is registered from the emit state; the receiver cannot stall
module voxel_ray_pick import vrp_pkg::*; #(
  parameter int GRID_SIZE = 32,
  parameter int MAX_STEPS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [4:0]         in_cell_x,
  input  logic [4:0]         in_cell_y,
  input  logic [4:0]         in_cell_z,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic signed [15:0] in_origin_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  output logic               out_valid,
  output logic               out_hit,
  output logic [2:0]         out_face,
  output logic signed [6:0]  out_place_x,
  output logic signed [6:0]  out_place_y,
  output logic signed [6:0]  out_place_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  vrp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  // datapath
  vrp_datapath #(
    .GRID_SIZE (GRID_SIZE),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (in_operation),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .in_cell_z    (in_cell_z),
    .in_origin_x  (in_origin_x),
    .in_origin_y  (in_origin_y),
    .in_origin_z  (in_origin_z),
    .in_dir_x     (in_dir_x),
    .in_dir_y     (in_dir_y),
    .in_dir_z     (in_dir_z),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_face     (out_face),
    .out_place_x  (out_place_x),
    .out_place_y  (out_place_y),
    .out_place_z  (out_place_z)
  );

  // a pick yields one beat, never two in a row
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back result beats");

  // a miss carries no face
  a_miss_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_face == FACE_NONE) else $error("face on a miss");

  // a miss keeps the last placement
  a_miss_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> $stable(out_place_x) && $stable(out_place_y) &&
    $stable(out_place_z)) else $error("placement moved on a miss");

  // set and clear beats give no result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != OP_PICK |=> !out_valid)
    else $error("result from a non-pick beat");

endmodule
